[design/bmpw_pkg.sv]
// Shared types, codes and defaults of the BMP to RGB565 window streamer.
package bmpw_pkg;

    localparam int MAX_IMAGE_WIDTH_DEF = 1280;
    localparam int SCREEN_LIMIT_DEF    = 2048;

    localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd480;
    localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd272;

    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;
    localparam logic [1:0] REG_ROW_OFFSET    = 2'd3;

    localparam logic [7:0] BITS_PER_PIXEL = 8'd24;

    typedef enum logic [1:0] {
        KIND_WINDOW = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    localparam logic [1:0] REJECT_PLANES      = 2'd0;
    localparam logic [1:0] REJECT_DEPTH       = 2'd1;
    localparam logic [1:0] REJECT_COMPRESSION = 2'd2;
    localparam logic [1:0] REJECT_SIZE        = 2'd3;

    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [11:0] column_offset;
        logic [11:0] row_offset;
    } cfg_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] col_start;
        logic [15:0] col_end;
        logic [15:0] row_addr;
        logic [15:0] pixel;
        logic [1:0]  reject_reason;
        logic        last_pixel;
    } result_t;

endpackage

[design/bmpw_in_reg.sv]
// Input register that holds one accepted file byte for the parse stage.
module bmpw_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tlast,
    input  logic               adv,
    output logic               vld,
    output bmpw_pkg::in_item_t item
);
    import bmpw_pkg::*;

    logic     vld_reg;
    in_item_t item_reg;

    assign s_tready = !vld_reg || adv;
    assign vld      = vld_reg;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.file_byte   <= s_tdata;
            item_reg.end_of_file <= s_tlast;
        end
    end

endmodule

[design/bmpw_parser.sv]
// Header capture, geometry setup and row/pixel sequencing for one file byte per cycle while adv is high.
module bmpw_parser #(
    parameter int MAX_IMAGE_WIDTH = bmpw_pkg::MAX_IMAGE_WIDTH_DEF,
    parameter int SCREEN_LIMIT    = bmpw_pkg::SCREEN_LIMIT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  bmpw_pkg::in_item_t item,
    input  bmpw_pkg::cfg_t     cfg,
    output logic               res_valid,
    output bmpw_pkg::result_t  res
);
    import bmpw_pkg::*;

    localparam int SC_W  = $clog2(SCREEN_LIMIT);
    localparam int SZ_W  = $clog2(SCREEN_LIMIT + 1);
    localparam int COL_W = $clog2(MAX_IMAGE_WIDTH + 2);
    localparam int LB_W  = $clog2(3 * MAX_IMAGE_WIDTH + 4);

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_GAP    = 5'b00010,
        PH_SKIP   = 5'b00100,
        PH_ROWS   = 5'b01000,
        PH_IGNORE = 5'b10000
    } phase_t;

    function automatic logic [SZ_W-1:0] eff_size(input logic [11:0] v);
        logic [31:0] v32;
        begin
            v32 = {20'd0, v};
            if (v32 == 32'd0)
            begin
                return SZ_W'(1);
            end
            if (v32 > 32'(SCREEN_LIMIT))
            begin
                return SZ_W'(SCREEN_LIMIT);
            end
            return SZ_W'(v32);
        end
    endfunction

    phase_t            phase_reg, phase_next, phase_eff;
    logic [31:0]       pos_reg, pos_next;
    logic [31:0]       offset_reg, offset_next;
    logic [31:0]       img_w_reg, img_w_next;
    logic [31:0]       img_h_reg, img_h_next;
    logic [2:0]        checks_reg, checks_next;
    logic [31:0]       skip_reg, skip_next;
    logic [SC_W-1:0]   row_reg, row_next;
    logic [LB_W-1:0]   rbc_reg, rbc_next;
    logic [1:0]        mod3_reg, mod3_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [10:0]       acc_reg, acc_next;
    logic [SC_W-1:0]   xs_reg, xs_next;
    logic [SC_W-1:0]   xe_reg, xe_next;
    logic [SC_W-1:0]   ys_reg, ys_next;
    logic [COL_W-1:0]  wcols_reg, wcols_next;
    logic [LB_W-1:0]   lb_reg, lb_next;

    logic [7:0]        b;
    logic [31:0]       sw32, sh32;
    logic [31:0]       xs32, xe32, ys32, ye32, lb32;
    logic [LB_W:0]     rbc_inc;
    logic              row_done;
    logic              size_bad;
    logic              last;
    logic [2:0]        chk;

    assign b        = item.file_byte;
    assign sw32     = 32'(eff_size(cfg.screen_width));
    assign sh32     = 32'(eff_size(cfg.screen_height));
    assign rbc_inc  = {1'b0, rbc_reg} + (LB_W + 1)'(1);
    assign row_done = rbc_inc >= {1'b0, lb_reg};
    assign size_bad = (img_w_reg == 32'd0) || (img_w_reg > 32'(MAX_IMAGE_WIDTH))
                      || (img_h_reg == 32'd0);
    assign last     = (row_reg == ys_reg) && (col_reg == wcols_reg - COL_W'(1));
    assign lb32     = ((img_w_reg << 1) + img_w_reg + 32'd3) & ~32'd3;

    always_comb
    begin
        if (img_w_reg > sw32)
        begin
            xs32 = 32'd0;
            xe32 = sw32 - 32'd1;
        end
        else
        begin
            xs32 = (sw32 - img_w_reg) >> 1;
            xe32 = xs32 + img_w_reg - 32'd1;
        end
        if (img_h_reg > sh32)
        begin
            ys32 = 32'd0;
            ye32 = sh32 - 32'd1;
        end
        else
        begin
            ys32 = (sh32 - img_h_reg) >> 1;
            ye32 = ys32 + img_h_reg - 32'd1;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = (pos_reg == 32'hFFFF_FFFF) ? pos_reg : pos_reg + 32'd1;
        offset_next = offset_reg;
        img_w_next  = img_w_reg;
        img_h_next  = img_h_reg;
        checks_next = checks_reg;
        skip_next   = skip_reg;
        row_next    = row_reg;
        rbc_next    = rbc_reg;
        mod3_next   = mod3_reg;
        col_next    = col_reg;
        acc_next    = acc_reg;
        xs_next     = xs_reg;
        xe_next     = xe_reg;
        ys_next     = ys_reg;
        wcols_next  = wcols_reg;
        lb_next     = lb_reg;
        chk         = checks_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.kind    = KIND_WINDOW;

        phase_eff = phase_reg;
        if (phase_reg == PH_GAP && pos_reg >= offset_reg)
        begin
            phase_eff = (skip_reg != 32'd0) ? PH_SKIP : PH_ROWS;
        end
        phase_next = phase_eff;

        case (phase_eff)
            PH_HEADER:
            begin
                case (pos_reg[5:0]) inside
                    6'd10: offset_next[7:0]   = b;
                    6'd11: offset_next[15:8]  = b;
                    6'd12: offset_next[23:16] = b;
                    6'd13: offset_next[31:24] = b;
                    6'd18: img_w_next[7:0]    = b;
                    6'd19: img_w_next[15:8]   = b;
                    6'd20: img_w_next[23:16]  = b;
                    6'd21: img_w_next[31:24]  = b;
                    6'd22: img_h_next[7:0]    = b;
                    6'd23: img_h_next[15:8]   = b;
                    6'd24: img_h_next[23:16]  = b;
                    6'd25: img_h_next[31:24]  = b;
                    6'd26: chk[0] = chk[0] | (b != 8'd1);
                    6'd27: chk[0] = chk[0] | (b != 8'd0);
                    6'd28: chk[1] = chk[1] | (b != BITS_PER_PIXEL);
                    6'd29: chk[1] = chk[1] | (b != 8'd0);
                    [6'd30:6'd33]: chk[2] = chk[2] | (b != 8'd0);
                    default: ;
                endcase
                checks_next = chk;
                if (pos_reg[5:0] == 6'd33)
                begin
                    if (chk[0] || chk[1] || chk[2] || size_bad)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_REJECT;
                        phase_next = PH_IGNORE;
                        if (chk[0])
                        begin
                            res.reject_reason = REJECT_PLANES;
                        end
                        else if (chk[1])
                        begin
                            res.reject_reason = REJECT_DEPTH;
                        end
                        else if (chk[2])
                        begin
                            res.reject_reason = REJECT_COMPRESSION;
                        end
                        else
                        begin
                            res.reject_reason = REJECT_SIZE;
                        end
                    end
                    else
                    begin
                        phase_next = PH_GAP;
                        xs_next    = xs32[SC_W-1:0];
                        xe_next    = xe32[SC_W-1:0];
                        ys_next    = ys32[SC_W-1:0];
                        row_next   = ye32[SC_W-1:0];
                        wcols_next = COL_W'(xe32 - xs32 + 32'd1);
                        skip_next  = (img_h_reg > sh32) ? img_h_reg - sh32 : 32'd0;
                        lb_next    = lb32[LB_W-1:0];
                        rbc_next   = '0;
                        mod3_next  = 2'd0;
                        col_next   = '0;
                        acc_next   = '0;
                    end
                end
            end
            PH_SKIP:
            begin
                if (row_done)
                begin
                    rbc_next  = '0;
                    skip_next = skip_reg - 32'd1;
                    if (skip_reg == 32'd1)
                    begin
                        phase_next = PH_ROWS;
                    end
                end
                else
                begin
                    rbc_next = rbc_inc[LB_W-1:0];
                end
            end
            PH_ROWS:
            begin
                if (rbc_reg == '0)
                begin
                    res_valid     = 1'b1;
                    res.kind      = KIND_WINDOW;
                    res.col_start = {4'd0, cfg.column_offset} + 16'(xs_reg);
                    res.col_end   = {4'd0, cfg.column_offset} + 16'(xe_reg);
                    res.row_addr  = {4'd0, cfg.row_offset} + 16'(row_reg);
                end
                if (mod3_reg == 2'd0)
                begin
                    acc_next = {6'd0, b[7:3]};
                end
                else if (mod3_reg == 2'd1)
                begin
                    acc_next = {b[7:2], acc_reg[4:0]};
                end
                else if (col_reg < wcols_reg)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_PIXEL;
                    res.pixel      = {b[7:3], acc_reg};
                    res.last_pixel = last;
                    if (last)
                    begin
                        phase_next = PH_IGNORE;
                    end
                end
                if (phase_next == PH_ROWS)
                begin
                    if (row_done)
                    begin
                        rbc_next  = '0;
                        mod3_next = 2'd0;
                        col_next  = '0;
                        if (row_reg > ys_reg)
                        begin
                            row_next = row_reg - SC_W'(1);
                        end
                        else
                        begin
                            phase_next = PH_IGNORE;
                        end
                    end
                    else
                    begin
                        rbc_next  = rbc_inc[LB_W-1:0];
                        mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                        col_next  = (mod3_reg == 2'd2) ? col_reg + COL_W'(1) : col_reg;
                    end
                end
            end
            default: ;
        endcase

        if (item.end_of_file)
        begin
            phase_next  = PH_HEADER;
            pos_next    = '0;
            offset_next = '0;
            img_w_next  = '0;
            img_h_next  = '0;
            checks_next = '0;
            skip_next   = '0;
            row_next    = '0;
            rbc_next    = '0;
            mod3_next   = 2'd0;
            col_next    = '0;
            acc_next    = '0;
            xs_next     = '0;
            xe_next     = '0;
            ys_next     = '0;
            wcols_next  = '0;
            lb_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            offset_reg <= '0;
            img_w_reg  <= '0;
            img_h_reg  <= '0;
            checks_reg <= '0;
            skip_reg   <= '0;
            row_reg    <= '0;
            rbc_reg    <= '0;
            mod3_reg   <= 2'd0;
            col_reg    <= '0;
            acc_reg    <= '0;
            xs_reg     <= '0;
            xe_reg     <= '0;
            ys_reg     <= '0;
            wcols_reg  <= '0;
            lb_reg     <= '0;
        end
        else if (adv)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            img_w_reg  <= img_w_next;
            img_h_reg  <= img_h_next;
            checks_reg <= checks_next;
            skip_reg   <= skip_next;
            row_reg    <= row_next;
            rbc_reg    <= rbc_next;
            mod3_reg   <= mod3_next;
            col_reg    <= col_next;
            acc_reg    <= acc_next;
            xs_reg     <= xs_next;
            xe_reg     <= xe_next;
            ys_reg     <= ys_next;
            wcols_reg  <= wcols_next;
            lb_reg     <= lb_next;
        end
    end

endmodule

[design/bmpw_out_reg.sv]
// Result register that drives the master-side stream.
module bmpw_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bmpw_pkg::result_t res,
    output logic              room,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [71:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import bmpw_pkg::*;

    logic    vld_reg;
    result_t res_reg;

    assign room     = !vld_reg || m_tready;
    assign m_tvalid = vld_reg;
    assign m_tdata  = {6'd0, res_reg.reject_reason, res_reg.pixel, res_reg.row_addr,
                       res_reg.col_end, res_reg.col_start};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (room)
        begin
            vld_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && load)
        begin
            res_reg <= res;
        end
    end

endmodule

[design/bmp24_to_rgb565_window_streamer.sv]
// Top level of the BMP 24-bit to RGB565 window streamer.
// The block takes one file byte per cycle on the slave side, sustained, as long as the
// master side keeps up. Each byte passes through an input register and one parse stage
// into a result register. A result is loaded into the result register as its byte leaves
// the input register; while a stalled item fills the result register, that byte waits.
// The single parse stage is combinational and updates all counters for a byte together.
// A result held on a stalled master side also holds back the next byte. A row window
// item precedes each drawn row, and one pixel item follows every third data byte inside
// the visible window. Registers should be written only while no item is in flight.
module bmp24_to_rgb565_window_streamer #(
    parameter int MAX_IMAGE_WIDTH = bmpw_pkg::MAX_IMAGE_WIDTH_DEF,
    parameter int SCREEN_LIMIT    = bmpw_pkg::SCREEN_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] file_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [15:0] col_start, [31:16] col_end, [47:32] row_addr,
                                    // [63:48] pixel, [65:64] reject_reason, [71:66] zero
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import bmpw_pkg::*;

    cfg_t     cfg_reg;
    in_item_t item;
    result_t  res;
    logic     in_vld;
    logic     res_valid;
    logic     room;
    logic     adv;

    assign adv = in_vld && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= SCREEN_WIDTH_RST;
            cfg_reg.screen_height <= SCREEN_HEIGHT_RST;
            cfg_reg.column_offset <= '0;
            cfg_reg.row_offset    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data;
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data;
                REG_COLUMN_OFFSET: cfg_reg.column_offset <= cfg_data;
                REG_ROW_OFFSET:    cfg_reg.row_offset    <= cfg_data;
                default: ;
            endcase
        end
    end

    bmpw_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .adv      (adv),
        .vld      (in_vld),
        .item     (item)
    );

    bmpw_parser #(
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH),
        .SCREEN_LIMIT    (SCREEN_LIMIT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .item      (item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    bmpw_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv && res_valid),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[design/bmpw_checker.sv]
// Port-level checker for the window streamer and its bind to the top level.
module bmpw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import bmpw_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result item changed while stalled.");

    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_WINDOW || m_tuser == KIND_PIXEL
                      || m_tuser == KIND_REJECT))
        else $error("Result item carries an unknown kind.");

    a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == KIND_PIXEL)
        else $error("Last marker on an item that is not a pixel.");

    a_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_PIXEL |-> m_tdata[63:48] == 16'd0)
        else $error("Pixel field set on an item that is not a pixel.");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_REJECT |-> m_tdata[47:0] == 48'd0)
        else $error("Address fields set on a reject item.");

endmodule

bind bmp24_to_rgb565_window_streamer bmpw_checker u_bmpw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[tb/tb_bmp24_to_rgb565_window_streamer.sv]
// Self-checking testbench for the BMP 24-bit to RGB565 window streamer.
`timescale 1ns / 1ps

module tb_bmp24_to_rgb565_window_streamer;
    import bmpw_pkg::*;

    typedef enum logic [4:0] {
        PARSE_HEADER = 5'b00001,
        PARSE_GAP    = 5'b00010,
        PARSE_SKIP   = 5'b00100,
        PARSE_ROWS   = 5'b01000,
        PARSE_DONE   = 5'b10000
    } parse_phase_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_SCREEN_WIDTH;
    logic [11:0] cfg_data  = 12'd0;

    // Register copies used by the predictor.
    logic [11:0] scr_w   = SCREEN_WIDTH_RST;
    logic [11:0] scr_h   = SCREEN_HEIGHT_RST;
    logic [11:0] col_off = 12'd0;
    logic [11:0] row_off = 12'd0;

    // Parser state of the predictor.
    logic [31:0]  parse_pos     = '0;
    logic [31:0]  data_offset   = '0;
    logic [31:0]  img_w         = '0;
    logic [31:0]  img_h         = '0;
    logic [31:0]  rows_to_skip  = '0;
    logic [2:0]   bad_fields    = '0;
    parse_phase_t phase         = PARSE_HEADER;
    logic [15:0]  cur_row       = '0;
    logic [15:0]  row_bytes     = '0;
    logic [15:0]  rgb_acc       = '0;
    logic [15:0]  win_first_col = '0;
    logic [15:0]  win_last_col  = '0;
    logic [15:0]  win_top_row   = '0;

    result_t    pending_q[$];
    logic [7:0] file_q[$];

    int errors;
    int bytes_sent;
    int files_sent;
    int windows_seen;
    int pixels_seen;
    int rejects_seen;
    int burst_left;
    int gap_max;
    int stall_mode;
    int stall_hold;

    bmp24_to_rgb565_window_streamer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR %s: got 0x%h, expected 0x%h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [31:0] clamp_size(input logic [11:0] v);
        if (v == 12'd0)
            return 32'd1;
        if (v > SCREEN_LIMIT_DEF)
            return 32'(SCREEN_LIMIT_DEF);
        return {20'd0, v};
    endfunction

    task automatic clear_parser();
        parse_pos     = '0;
        data_offset   = '0;
        img_w         = '0;
        img_h         = '0;
        rows_to_skip  = '0;
        bad_fields    = '0;
        phase         = PARSE_HEADER;
        cur_row       = '0;
        row_bytes     = '0;
        rgb_acc       = '0;
        win_first_col = '0;
        win_last_col  = '0;
        win_top_row   = '0;
    endtask

    // Works out the result, if any, that one accepted file byte causes.
    task automatic predict_byte(input logic [7:0] b, input logic eof);
        logic [31:0] sw;
        logic [31:0] sh;
        logic [31:0] xs;
        logic [31:0] ys;
        logic [31:0] ye;
        logic [31:0] r;
        logic [31:0] w;
        logic [31:0] stride;
        logic [1:0]  why;
        logic        flagged;
        logic        last;
        result_t     want;
        want = '0;
        if (phase == PARSE_HEADER)
        begin
            if (parse_pos >= 10 && parse_pos <= 13)
                data_offset[8 * (parse_pos - 10) +: 8] = b;
            else if (parse_pos >= 18 && parse_pos <= 21)
                img_w[8 * (parse_pos - 18) +: 8] = b;
            else if (parse_pos >= 22 && parse_pos <= 25)
                img_h[8 * (parse_pos - 22) +: 8] = b;
            else if ((parse_pos == 26 && b != 8'd1) || (parse_pos == 27 && b != 8'd0))
                bad_fields[0] = 1'b1;
            else if ((parse_pos == 28 && b != BITS_PER_PIXEL) || (parse_pos == 29 && b != 8'd0))
                bad_fields[1] = 1'b1;
            else if (parse_pos >= 30 && parse_pos <= 33 && b != 8'd0)
                bad_fields[2] = 1'b1;
            if (parse_pos == 33)
            begin
                flagged = 1'b1;
                why = REJECT_PLANES;
                if (bad_fields[0])
                    why = REJECT_PLANES;
                else if (bad_fields[1])
                    why = REJECT_DEPTH;
                else if (bad_fields[2])
                    why = REJECT_COMPRESSION;
                else if (img_w == 0 || img_w > MAX_IMAGE_WIDTH_DEF || img_h == 0)
                    why = REJECT_SIZE;
                else
                    flagged = 1'b0;
                if (flagged)
                begin
                    want.kind = KIND_REJECT;
                    want.reject_reason = why;
                    pending_q.push_back(want);
                    phase = PARSE_DONE;
                end
                else
                begin
                    sw = clamp_size(scr_w);
                    sh = clamp_size(scr_h);
                    if (img_w > sw)
                    begin
                        xs = 0;
                        win_last_col = 16'(sw - 1);
                    end
                    else
                    begin
                        xs = (sw - img_w) / 2;
                        win_last_col = 16'(xs + img_w - 1);
                    end
                    win_first_col = xs[15:0];
                    if (img_h > sh)
                    begin
                        ys = 0;
                        ye = sh - 1;
                        rows_to_skip = img_h - sh;
                    end
                    else
                    begin
                        ys = (sh - img_h) / 2;
                        ye = ys + img_h - 1;
                        rows_to_skip = 0;
                    end
                    win_top_row = ys[15:0];
                    cur_row = ye[15:0];
                    row_bytes = '0;
                    rgb_acc = '0;
                    phase = PARSE_GAP;
                end
            end
        end
        else
        begin
            if (phase == PARSE_GAP && parse_pos >= data_offset)
                phase = (rows_to_skip != 0) ? PARSE_SKIP : PARSE_ROWS;
            stride = ((img_w * 3) + 3) & ~32'd3;
            r = {16'd0, row_bytes};
            if (phase == PARSE_SKIP)
            begin
                if (r + 1 >= stride)
                begin
                    row_bytes = '0;
                    rows_to_skip--;
                    if (rows_to_skip == 0)
                        phase = PARSE_ROWS;
                end
                else
                    row_bytes = row_bytes + 16'd1;
            end
            else if (phase == PARSE_ROWS)
            begin
                w = {16'd0, win_last_col - win_first_col} + 1;
                if (r == 0)
                begin
                    want.kind = KIND_WINDOW;
                    want.col_start = {4'd0, col_off} + win_first_col;
                    want.col_end = {4'd0, col_off} + win_last_col;
                    want.row_addr = {4'd0, row_off} + cur_row;
                    pending_q.push_back(want);
                end
                if (r % 3 == 0)
                    rgb_acc = {11'd0, b[7:3]};
                else if (r % 3 == 1)
                    rgb_acc = rgb_acc | {5'd0, b[7:2], 5'd0};
                else if (r < 3 * w)
                begin
                    last = (cur_row == win_top_row) && (r / 3 == w - 1);
                    want.kind = KIND_PIXEL;
                    want.pixel = rgb_acc | {b[7:3], 11'd0};
                    want.last_pixel = last;
                    pending_q.push_back(want);
                    if (last)
                        phase = PARSE_DONE;
                end
                if (phase == PARSE_ROWS)
                begin
                    if (r + 1 >= stride)
                    begin
                        row_bytes = '0;
                        if (cur_row > win_top_row)
                            cur_row = cur_row - 16'd1;
                        else
                            phase = PARSE_DONE;
                    end
                    else
                        row_bytes = 16'(r + 1);
                end
            end
        end
        if (parse_pos != 32'hFFFF_FFFF)
            parse_pos++;
        if (eof)
            clear_parser();
    endtask

    task automatic check_result();
        result_t want;
        if (pending_q.size() == 0)
        begin
            report_mismatch("result with nothing pending", {14'd0, m_tuser}, 16'd0);
            return;
        end
        want = pending_q.pop_front();
        if (m_tuser !== want.kind)
            report_mismatch("kind", {14'd0, m_tuser}, {14'd0, want.kind});
        if (m_tdata[15:0] !== want.col_start)
            report_mismatch("col_start", m_tdata[15:0], want.col_start);
        if (m_tdata[31:16] !== want.col_end)
            report_mismatch("col_end", m_tdata[31:16], want.col_end);
        if (m_tdata[47:32] !== want.row_addr)
            report_mismatch("row_addr", m_tdata[47:32], want.row_addr);
        if (m_tdata[63:48] !== want.pixel)
            report_mismatch("pixel", m_tdata[63:48], want.pixel);
        if (m_tdata[65:64] !== want.reject_reason)
            report_mismatch("reject_reason", {14'd0, m_tdata[65:64]}, {14'd0, want.reject_reason});
        if (m_tlast !== want.last_pixel)
            report_mismatch("last_pixel", {15'd0, m_tlast}, {15'd0, want.last_pixel});
        case (want.kind)
            KIND_WINDOW: windows_seen++;
            KIND_PIXEL:  pixels_seen++;
            default:     rejects_seen++;
        endcase
    endtask

    // Result side: checks each accepted item and stalls on its own pattern.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            check_result();
        if (stall_mode == 0)
            m_tready <= 1'b1;
        else if (stall_mode == 1)
            m_tready <= ($urandom_range(0, 3) != 0);
        else if (stall_hold > 0)
        begin
            stall_hold--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_hold = $urandom_range(1, 12);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic drive_byte(input logic [7:0] b, input logic eof);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eof;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        predict_byte(b, eof);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            drive_byte(file_q[i], i == file_q.size() - 1);
        files_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_SCREEN_WIDTH:  scr_w = val;
            REG_SCREEN_HEIGHT: scr_h = val;
            REG_COLUMN_OFFSET: col_off = val;
            default:           row_off = val;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_screen(input logic [11:0] sw, input logic [11:0] sh,
                              input logic [11:0] co, input logic [11:0] ro);
        drain();
        write_reg(REG_SCREEN_WIDTH, sw);
        write_reg(REG_SCREEN_HEIGHT, sh);
        write_reg(REG_COLUMN_OFFSET, co);
        write_reg(REG_ROW_OFFSET, ro);
    endtask

    task automatic put_word(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(v[8 * i +: 8]);
    endtask

    // Header of 34 bytes: signature, size, reserved, data offset, info size,
    // width, height, planes, bit depth and compression.
    task automatic begin_file(input logic [31:0] offset, input logic [31:0] w,
                              input logic [31:0] h, input logic [15:0] planes,
                              input logic [15:0] bpp, input logic [31:0] comp);
        file_q.delete();
        file_q.push_back(8'h42);
        file_q.push_back(8'h4D);
        put_word($urandom(), 4);
        put_word($urandom(), 4);
        put_word(offset, 4);
        put_word(32'd40, 4);
        put_word(w, 4);
        put_word(h, 4);
        put_word({16'd0, planes}, 2);
        put_word({16'd0, bpp}, 2);
        put_word(comp, 4);
    endtask

    // Pads with random bytes up to the data offset, then adds n random bytes.
    task automatic add_body(input logic [31:0] offset, input int unsigned n);
        while (file_q.size() < offset)
            file_q.push_back(8'($urandom()));
        repeat (n) file_q.push_back(8'($urandom()));
    endtask

    task automatic trim_file(input int unsigned n);
        while (file_q.size() > n)
            void'(file_q.pop_back());
    endtask

    task automatic test_reject_order();
        gap_max = 2;
        stall_mode = 1;
        begin_file(54, 4, 4, 16'd2, 16'd24, 32'd0);
        send_file();
        begin_file(54, 4, 4, 16'h0101, 16'd32, 32'd1);
        send_file();
        begin_file(54, 4, 4, 16'd1, 16'h0118, 32'd3);
        send_file();
        begin_file(54, 4, 4, 16'd1, 16'd24, 32'h0100_0000);
        add_body(0, 6);
        send_file();
        begin_file(54, 0, 4, 16'd1, 16'd24, 32'd0);
        send_file();
        begin_file(54, 1281, 4, 16'd1, 16'd24, 32'd0);
        send_file();
        begin_file(54, 4, 0, 16'd1, 16'd24, 32'd0);
        send_file();
    endtask

    task automatic test_centered_window();
        gap_max = 0;
        stall_mode = 0;
        begin_file(54, 3, 2, 16'd1, 16'd24, 32'd0);
        add_body(54, 24);
        send_file();
    endtask

    task automatic test_clip_and_skip();
        set_screen(12'd4, 12'd3, 12'd7, 12'd9);
        gap_max = 4;
        stall_mode = 2;
        begin_file(0, 6, 5, 16'd1, 16'd24, 32'd0);
        add_body(0, 100);
        add_body(0, 4);
        send_file();
    endtask

    task automatic test_screen_extremes();
        set_screen(12'd0, 12'd0, 12'd4095, 12'd4095);
        begin_file(34, 2, 3, 16'd1, 16'd24, 32'd0);
        add_body(34, 24);
        send_file();
        set_screen(12'd4095, 12'd4095, 12'd0, 12'd0);
        begin_file(40, 1, 1, 16'd1, 16'd24, 32'd0);
        add_body(40, 4);
        send_file();
        set_screen(12'd2048, 12'd1, 12'd1, 12'd2);
        begin_file(54, 5, 2, 16'd1, 16'd24, 32'd0);
        add_body(54, 32);
        send_file();
        set_screen(12'd2, 12'd2, 12'd1, 12'd2);
        begin_file(54, 1280, 1, 16'd1, 16'd24, 32'd0);
        add_body(54, 9);
        send_file();
    endtask

    task automatic test_cut_files();
        set_screen(12'd8, 12'd6, 12'd3, 12'd5);
        gap_max = 3;
        stall_mode = 1;
        begin_file(54, 4, 4, 16'd1, 16'd24, 32'd0);
        trim_file(21);
        send_file();
        begin_file(32'hFFFF_FFFF, 2, 2, 16'd1, 16'd24, 32'd0);
        add_body(0, 12);
        send_file();
        begin_file(54, 2, 32'h7FFF_FFFF, 16'd1, 16'd24, 32'd0);
        add_body(54, 30);
        send_file();
        begin_file(54, 3, 3, 16'd1, 16'd24, 32'd0);
        add_body(54, 18);
        send_file();
    endtask

    function automatic logic [11:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'd1;
            2:       return 12'd2048;
            3:       return 12'd4095;
            4:       return 12'($urandom_range(0, 4095));
            default: return 12'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [11:0] pick_offset();
        case ($urandom_range(0, 3))
            0:       return 12'd0;
            1:       return 12'd4095;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic random_file();
        int unsigned pick;
        int unsigned sel;
        logic [31:0] offset;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] planes;
        logic [15:0] bpp;
        logic [31:0] comp;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       offset = $urandom_range(0, 33);
            1:       offset = 34;
            2:       offset = 54;
            default: offset = $urandom_range(35, 80);
        endcase
        planes = 16'd1;
        bpp = 16'd24;
        comp = 32'd0;
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 7);
        if (pick < 10)
        begin
            file_q.delete();
            repeat ($urandom_range(1, 60)) file_q.push_back(8'($urandom()));
        end
        else if (pick < 22)
        begin
            sel = $urandom_range(0, 4);
            if (sel == 0)
            begin
                planes = 16'($urandom());
                if (planes == 16'd1)
                    planes = 16'd0;
            end
            else if (sel == 1)
            begin
                bpp = 16'($urandom());
                if (bpp == 16'd24)
                    bpp = 16'd0;
            end
            else if (sel == 2)
                comp = $urandom() | (32'd1 << $urandom_range(0, 31));
            else if (sel == 3)
                w = $urandom_range(0, 1) ? 32'd0 : $urandom_range(1281, 32'hFFFF_FFFF);
            else
                h = 32'd0;
            if ($urandom_range(0, 1))
                bpp = 16'($urandom());
            if ($urandom_range(0, 1))
                comp = $urandom();
            begin_file(offset, w, h, planes, bpp, comp);
            add_body(0, $urandom_range(0, 10));
        end
        else if (pick < 27)
        begin
            begin_file(offset, $urandom_range(200, 1280), $urandom_range(1, 3),
                       planes, bpp, comp);
            add_body(offset, $urandom_range(3, 40));
        end
        else
        begin
            begin_file(offset, w, h, planes, bpp, comp);
            add_body(offset, (((w * 3) + 3) & ~32'd3) * h);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                trim_file($urandom_range(1, file_q.size()));
            else if (sel < 3)
                add_body(0, $urandom_range(1, 8));
        end
    endtask

    task automatic test_random_files(input int unsigned target);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            if ($urandom_range(0, 3) == 0)
                set_screen(pick_size(), pick_size(), pick_offset(), pick_offset());
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 2;
                default: gap_max = 8;
            endcase
            stall_mode = $urandom_range(0, 2);
            random_file();
            send_file();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reject_order();
        test_centered_window();
        test_clip_and_skip();
        test_screen_extremes();
        test_cut_files();
        test_random_files(900);
        drain();
        $display("Streamed %0d files in %0d bytes under varied screen settings and flow control.",
                 files_sent, bytes_sent);
        $display("Checked %0d row windows, %0d pixels and %0d rejections; %0d mismatches.",
                 windows_seen, pixels_seen, rejects_seen, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results still pending.", pending_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
